FILE: rtl/fsps_pkg.sv
// Shared constants, types and command codes for the substring position search.
package fsps_pkg;

  localparam int KEY_MAX = 16;
  localparam int IDX_W   = $clog2(KEY_MAX);
  localparam int LEN_W   = $clog2(KEY_MAX + 1);

  localparam int POS_W   = 16;
  localparam longint unsigned TEXT_MAX   = 64'd65535;
  localparam longint unsigned TEXT_LIMIT = (TEXT_MAX < 64'd65535) ? TEXT_MAX : 64'd65535;

  typedef logic [7:0] byte_t;
  typedef byte_t [KEY_MAX-1:0] lane_vec_t;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_KEY   = 2'd1,
    CMD_TEXT  = 2'd2,
    CMD_END   = 2'd3
  } cmd_e;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_KEY_LONG = 2'd1;
  localparam logic [1:0] STATUS_TEXT_LONG = 2'd2;

endpackage

FILE: rtl/first_substring_position_search_core.sv
// Top level of the first substring position search core.
//
// One input channel carries commands (cmd_i, data_byte_i): clear and start,
// append a key byte, a text byte, or end of text. One output channel
// carries the answer to each end command: position_o (1-based start of the
// first match, 0 for none, 1 for an empty key) and status_o (first error
// since the last clear). Both channels transfer on valid high, stall low.
//
// Throughput is one command per cycle while the receiver does not stall a
// waiting result: each command is registered, then processed by a 16-lane
// parallel window compare that updates the search state. An end command
// passes from the input register into the result register, which offers it.
//
// When the receiver stalls a waiting result, a command held in the input
// register waits and in_stall_o rises; if the input register is empty, one
// further command can enter it meanwhile. Reset empties both registers and
// returns the search to the cleared state, as a clear command does.
module first_substring_position_search_core
  import fsps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       cmd_i,
  input  logic [7:0]       data_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [POS_W-1:0] position_o,
  output logic [1:0]       status_o
);

  // input register
  logic  s1_valid_q, s1_valid_d;
  cmd_e  s1_cmd_q;
  byte_t s1_byte_q;

  // search state
  lane_vec_t        key_q;
  logic [LEN_W-1:0] key_len_q, key_len_d;
  lane_vec_t        win_q, win_d;
  logic [POS_W-1:0] text_cnt_q, text_cnt_d;
  logic [POS_W-1:0] match_pos_q, match_pos_d;
  logic             found_q, found_d;
  logic [1:0]       err_q, err_d;

  // result register
  logic             out_valid_q, out_valid_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [1:0]       status_q, status_d;

  logic      out_free, s1_fire, in_take, key_wr;
  lane_vec_t win_shift;
  logic [POS_W-1:0] cnt_inc;
  logic      win_match;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign win_shift = {s1_byte_q, win_q[KEY_MAX-1:1]};
  assign cnt_inc   = text_cnt_q + POS_W'(1);

  fsps_window_match u_match (
    .key_i     (key_q),
    .win_i     (win_shift),
    .key_len_i (key_len_q),
    .match_o   (win_match)
  );

  always_comb begin
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_comb begin
    key_len_d   = key_len_q;
    win_d       = win_q;
    text_cnt_d  = text_cnt_q;
    match_pos_d = match_pos_q;
    found_d     = found_q;
    err_d       = err_q;
    key_wr      = 1'b0;
    if (s1_fire) begin
      unique case (s1_cmd_q)
        CMD_CLEAR: begin
          key_len_d   = '0;
          win_d       = '0;
          text_cnt_d  = '0;
          match_pos_d = '0;
          found_d     = 1'b0;
          err_d       = STATUS_OK;
        end
        CMD_KEY: begin
          if (key_len_q < LEN_W'(KEY_MAX)) begin
            key_wr    = 1'b1;
            key_len_d = key_len_q + LEN_W'(1);
          end else if (err_q == STATUS_OK) begin
            err_d = STATUS_KEY_LONG;
          end
        end
        CMD_TEXT: begin
          if (text_cnt_q >= POS_W'(TEXT_LIMIT)) begin
            if (err_q == STATUS_OK) begin
              err_d = STATUS_TEXT_LONG;
            end
          end else begin
            text_cnt_d = cnt_inc;
            win_d      = win_shift;
            if (!found_q && (key_len_q != '0) &&
                (cnt_inc >= POS_W'(key_len_q)) && win_match) begin
              found_d     = 1'b1;
              match_pos_d = cnt_inc - POS_W'(key_len_q) + POS_W'(1);
            end
          end
        end
        CMD_END: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    pos_d       = pos_q;
    status_d    = status_q;
    if (s1_fire && (s1_cmd_q == CMD_END)) begin
      out_valid_d = 1'b1;
      status_d    = err_q;
      if (key_len_q == '0) begin
        pos_d = POS_W'(1);
      end else if (found_q) begin
        pos_d = match_pos_q;
      end else begin
        pos_d = '0;
      end
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      key_len_q   <= '0;
      win_q       <= '0;
      text_cnt_q  <= '0;
      match_pos_q <= '0;
      found_q     <= 1'b0;
      err_q       <= STATUS_OK;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      key_len_q   <= key_len_d;
      win_q       <= win_d;
      text_cnt_q  <= text_cnt_d;
      match_pos_q <= match_pos_d;
      found_q     <= found_d;
      err_q       <= err_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_cmd_q  <= cmd_e'(cmd_i);
      s1_byte_q <= data_byte_i;
    end
    if (key_wr) begin
      key_q[key_len_q[IDX_W-1:0]] <= s1_byte_q;
    end
    pos_q    <= pos_d;
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = pos_q;
  assign status_o    = status_q;

endmodule

FILE: rtl/fsps_window_match.sv
// Parallel compare of the key against the tail of the text window.
module fsps_window_match
  import fsps_pkg::*;
(
  input  lane_vec_t        key_i,
  input  lane_vec_t        win_i,
  input  logic [LEN_W-1:0] key_len_i,
  output logic             match_o
);

  logic [KEY_MAX-1:0] lane_ok;

  // lane i checks key byte i against window byte KEY_MAX - key_len + i
  always_comb begin
    logic [LEN_W-1:0] idx;
    for (int i = 0; i < KEY_MAX; i++) begin
      idx = LEN_W'(KEY_MAX) - key_len_i + LEN_W'(i);
      if (LEN_W'(i) < key_len_i) begin
        lane_ok[i] = (win_i[idx[IDX_W-1:0]] == key_i[i]);
      end else begin
        lane_ok[i] = 1'b1;
      end
    end
  end

  assign match_o = &lane_ok;

endmodule
